>>> design/sapq_pkg.sv
// Shared types and codes for the sorted-array priority queue.
// No dependencies; every other design file refers to this package by scope.
`timescale 1ns / 1ps

package sapq_pkg;

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Broadcast to every cell of the chain each cycle.
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

>>> design/sapq_if.sv
// Channel interfaces: request (mode, value) and response (result fields).
// Depends on sapq_pkg for the status type.
`timescale 1ns / 1ps

interface sapq_req_if #(parameter int VALUE_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source(output valid, mode, value, input ready);
	modport sink(input valid, mode, value, output ready);
endinterface

interface sapq_rsp_if #(parameter int VALUE_WIDTH = 32, parameter int COUNT_WIDTH = 7) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] out_value;
	logic                          out_valid;
	sapq_pkg::status_t             status;
	logic [COUNT_WIDTH-1:0]        count_now;

	modport source(output valid, out_value, out_valid, status, count_now, input ready);
	modport sink(input valid, out_value, out_valid, status, count_now, output ready);
endinterface

>>> design/sapq_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the
// broadcast value and takes from a neighbor on shift. Depends on sapq_pkg.
`timescale 1ns / 1ps

module sapq_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  sapq_pkg::cell_ctrl_t          ctrl,
	input  logic                          occupied,
	input  logic signed [VALUE_WIDTH-1:0] x,
	input  logic signed [VALUE_WIDTH-1:0] prev_value,
	input  logic                          prev_lt,
	input  logic signed [VALUE_WIDTH-1:0] next_value,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic                          lt
);

	logic signed [VALUE_WIDTH-1:0] value_q;

	// Cells holding something strictly smaller stay; equal ones move up so
	// the newest copy sits nearest the head.
	assign lt    = occupied && (value_q < x);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!lt) begin
				value_q <= prev_lt ? x : prev_value;
			end
		end else if (ctrl.deq) begin
			value_q <= next_value;
		end
	end

endmodule

>>> design/sorted_array_priority_queue.sv
// Each result is written into the response register when its transaction is accepted.
// Throughput: one transaction per cycle while the response side takes results;
// every cell of the chain compares and shifts in the same cycle.
// Reset (arst_n, async, active low) empties the queue and drops any pending result;
// cell contents are not reset and are only read below the entry count.
`timescale 1ns / 1ps

module sorted_array_priority_queue #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	sapq_req_if.sink   req,
	sapq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                 count_q;
	logic                          rsp_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic                          out_valid_q;
	sapq_pkg::status_t             status_q;
	logic [CW-1:0]                 count_now_q;

	logic                          accept;
	logic                          full;
	logic                          empty;
	logic                          is_deq;
	sapq_pkg::cell_ctrl_t          ctrl;
	logic [CW-1:0]                 count_next;

	logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic                          cell_lt    [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign is_deq    = (req.mode == sapq_pkg::MODE_DEQ);
	assign ctrl.enq  = accept && !is_deq && !full;
	assign ctrl.deq  = accept && is_deq && !empty;

	always_comb begin
		count_next = count_q;
		if (ctrl.enq) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.deq) begin
			count_next = count_q - CW'(1);
		end
	end

	// Cell 0 holds the smallest entry; entries grow toward higher indexes.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] prev_v;
		logic                          prev_l;
		logic signed [VALUE_WIDTH-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = req.value;
			assign prev_l = 1'b1;
		end else begin : g_mid
			assign prev_v = cell_value[i-1];
			assign prev_l = cell_lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_v = cell_value[i];
		end else begin : g_inner
			assign next_v = cell_value[i+1];
		end

		sapq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (count_q > CW'(i)),
			.x         (req.value),
			.prev_value(prev_v),
			.prev_lt   (prev_l),
			.next_value(next_v),
			.value     (cell_value[i]),
			.lt        (cell_lt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q <= ctrl.deq ? cell_value[0] : '0;
			out_valid_q <= ctrl.deq;
			count_now_q <= count_next;
			if (!is_deq && full) begin
				status_q <= sapq_pkg::ST_FULL;
			end else if (is_deq && empty) begin
				status_q <= sapq_pkg::ST_EMPTY;
			end else begin
				status_q <= sapq_pkg::ST_OK;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_value = out_value_q;
	assign rsp.out_valid = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.count_now = count_now_q;

endmodule

>>> design/sapq_checker.sv
// Port-level checks on the response channel of the priority queue,
// bound to sorted_array_priority_queue. Depends on sapq_pkg.
`timescale 1ns / 1ps

module sapq_checker #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32,
	parameter int CW          = $clog2(DEPTH + 1)
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [VALUE_WIDTH-1:0] out_value,
	input logic                   out_valid,
	input sapq_pkg::status_t      status,
	input logic [CW-1:0]          count_now
);

	// A refused enqueue only happens with the store full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == sapq_pkg::ST_FULL) |-> (count_now == CW'(DEPTH)))
		else $error("full status with count below depth");

	// A refused dequeue only happens with the store empty.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == sapq_pkg::ST_EMPTY) |-> (count_now == '0))
		else $error("empty status with nonzero count");

	// A delivered value means a successful dequeue, which leaves room.
	a_deq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && out_valid) |-> (status == sapq_pkg::ST_OK && count_now != CW'(DEPTH)))
		else $error("dequeued value with bad status or count");

	// Stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_value) && $stable(out_valid)
			&& $stable(status) && $stable(count_now)))
		else $error("response changed while stalled");

endmodule

bind sorted_array_priority_queue sapq_checker #(
	.DEPTH      (DEPTH),
	.VALUE_WIDTH(VALUE_WIDTH)
) u_sapq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.out_value(rsp.out_value),
	.out_valid(rsp.out_valid),
	.status   (rsp.status),
	.count_now(rsp.count_now)
);
